### rtl/core/tfm_pkg.sv
// Package for the topic filter matcher: character codes, queue entry type
// and sizing constants. No dependencies.
`default_nettype none

package tfm_pkg;

    localparam int FILTER_CHARS_DEF = 64;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_TOPIC = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t        op;
        logic [7:0] ch;
        logic       last;
        logic       slash;
    } tfm_entry_t;

    typedef struct packed
    {
        logic       head_valid;
        tfm_entry_t head;
    } tfm_queue_t;

endpackage

`default_nettype wire

### rtl/core/tfm_front.sv
// Front end of the topic filter matcher: accepts requests, tags topic '/'
// bytes and holds them in a short queue. Uses tfm_pkg.
`default_nettype none

module tfm_front
    import tfm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [0:0]  operation,
    input  wire logic [7:0]  char_in,
    input  wire logic        last,
    output tfm_queue_t       queue,
    input  wire logic        pop
);

    tfm_entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg;
    logic [QCNT_W-1:0]       count_next;
    logic                    push;
    logic                    do_pop;
    tfm_entry_t              incoming;

    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign do_pop     = pop && (count_reg != '0);

    always_comb
    begin
        incoming.op    = op_t'(operation);
        incoming.ch    = char_in;
        incoming.last  = last;
        incoming.slash = (op_t'(operation) == OP_TOPIC) && (char_in == CH_SLASH);
    end

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

    always_comb
    begin
        queue.head_valid = (count_reg != '0);
        queue.head       = slot_reg[rd_ptr_reg];
    end

endmodule

`default_nettype wire

### rtl/core/tfm_back.sv
// Back end of the topic filter matcher: filter store, match state, end of
// topic walk and the result register. Uses tfm_pkg.
`default_nettype none

module tfm_back
    import tfm_pkg::*;
#(
    parameter int FILTER_CHARS = FILTER_CHARS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tfm_queue_t  queue,
    output logic             pop,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             matched
);

    localparam int AW = $clog2(FILTER_CHARS);
    localparam int LW = $clog2(FILTER_CHARS + 1);

    logic [7:0]    store_mem [FILTER_CHARS];
    logic [7:0]    cur_reg;            // store_mem[pos_reg], with write bypass

    logic [LW-1:0] len_reg, len_next;
    logic          closed_reg, closed_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic          skip_reg, skip_next;
    logic          failed_reg, failed_next;
    logic          hash_reg, hash_next;
    logic          fin_reg, fin_next;
    logic          out_valid_reg, out_valid_next;
    logic          matched_reg, matched_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          out_free;
    logic          emit;
    logic          emit_val;
    logic          step_done;
    logic          f_upd, h_upd, s_upd;
    logic [LW-1:0] p_upd;
    tfm_entry_t    e;

    assign e        = queue.head;
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        len_next    = len_reg;
        closed_next = closed_reg;
        pos_next    = pos_reg;
        skip_next   = skip_reg;
        failed_next = failed_reg;
        hash_next   = hash_reg;
        fin_next    = fin_reg;
        pop         = 1'b0;
        emit        = 1'b0;
        emit_val    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        step_done   = 1'b1;
        f_upd       = failed_reg;
        h_upd       = hash_reg;
        s_upd       = skip_reg;
        p_upd       = pos_reg;

        if (fin_reg)
        begin
            // walk the rest of the filter: only '+' bytes, maybe ending in '#'
            if (out_free)
            begin
                if (pos_reg >= len_reg || cur_reg == CH_HASH)
                begin
                    emit     = 1'b1;
                    emit_val = 1'b1;
                end
                else if (cur_reg != CH_PLUS)
                begin
                    emit     = 1'b1;
                    emit_val = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg + LW'(1);
                end
            end
        end
        else if (queue.head_valid)
        begin
            if (e.op == OP_LOAD)
            begin
                pop = 1'b1;
                if (closed_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = '0;
                    len_next = LW'(1);
                end
                else if (len_reg < LW'(FILTER_CHARS))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = len_reg[AW-1:0];
                    len_next = len_reg + LW'(1);
                end
                closed_next = e.last;
            end
            else if (!e.last || out_free)
            begin
                if (!failed_reg && !hash_reg && !(skip_reg && !e.slash))
                begin
                    s_upd = 1'b0;
                    if (pos_reg >= len_reg)
                    begin
                        f_upd = 1'b1;
                    end
                    else if (cur_reg == CH_HASH)
                    begin
                        h_upd = 1'b1;
                    end
                    else if (cur_reg == CH_PLUS)
                    begin
                        // a '/' byte passes an empty level: stay on this byte
                        p_upd     = pos_reg + LW'(1);
                        s_upd     = 1'b1;
                        step_done = !e.slash;
                    end
                    else if (cur_reg == e.ch)
                    begin
                        p_upd = pos_reg + LW'(1);
                    end
                    else
                    begin
                        f_upd = 1'b1;
                    end
                end

                failed_next = f_upd;
                hash_next   = h_upd;
                skip_next   = s_upd;
                pos_next    = p_upd;

                if (step_done)
                begin
                    pop = 1'b1;
                    if (e.last)
                    begin
                        if (f_upd)
                        begin
                            emit     = 1'b1;
                            emit_val = 1'b0;
                        end
                        else if (h_upd || p_upd >= len_reg)
                        begin
                            emit     = 1'b1;
                            emit_val = 1'b1;
                        end
                        else
                        begin
                            fin_next = 1'b1;
                        end
                    end
                end
            end
        end

        if (emit)
        begin
            pos_next    = '0;
            skip_next   = 1'b0;
            failed_next = 1'b0;
            hash_next   = 1'b0;
            fin_next    = 1'b0;
        end

        out_valid_next = out_valid_reg && result_stall;
        matched_next   = matched_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            matched_next   = emit_val;
        end
    end

    assign rd_addr = pos_next[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            closed_reg    <= 1'b1;
            pos_reg       <= '0;
            skip_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            hash_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            closed_reg    <= closed_next;
            pos_reg       <= pos_next;
            skip_reg      <= skip_next;
            failed_reg    <= failed_next;
            hash_reg      <= hash_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        if (wr_en)
        begin
            store_mem[wr_addr] <= e.ch;
        end
        if (wr_en && wr_addr == rd_addr)
        begin
            cur_reg <= e.ch;
        end
        else
        begin
            cur_reg <= store_mem[rd_addr];
        end
    end

    assign result_valid = out_valid_reg;
    assign matched      = matched_reg;

endmodule

`default_nettype wire

### rtl/core/topic_filter_match.sv
// Top level of the topic filter matcher: front queue and back matcher.
// Uses tfm_pkg, tfm_front and tfm_back.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------
//  item     | item_valid / item_stall     | operation, char_in, last
//  result   | result_valid / result_stall | matched
//
// One request per cycle for filter bytes and ordinary topic bytes while the
// queue has room; the back end reads one filter byte per cycle from its store.
// A topic '/' that meets a '+' in the filter stays at the queue head while
// the back end passes each '+'. A topic's last byte ends the topic when the
// match is settled there, else the back end walks the remaining '+' bytes
// until a byte or the filter end settles it.
// Reset is asynchronous; the filter store needs no clearing pass.
// A four-deep queue keeps taking requests while a result waits to be taken.
`default_nettype none

module topic_filter_match
    import tfm_pkg::*;
#(
    parameter int FILTER_CHARS = FILTER_CHARS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [0:0]  operation,
    input  wire logic [7:0]  char_in,
    input  wire logic        last,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             matched
);

    tfm_queue_t queue;
    logic       pop;

    tfm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .operation  (operation),
        .char_in    (char_in),
        .last       (last),
        .queue      (queue),
        .pop        (pop)
    );

    tfm_back #(
        .FILTER_CHARS (FILTER_CHARS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue        (queue),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched)
    );

endmodule

`default_nettype wire

### rtl/core/tfm_checker.sv
// Port-level checks for topic_filter_match, attached with a bind.
// Depends only on the top level's ports.
`default_nettype none

module tfm_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire logic        item_stall,
    input  wire logic [0:0]  operation,
    input  wire logic        last,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire logic        matched
);

    // topics ended but not yet delivered
    logic [3:0] pending_reg;
    logic       topic_end;
    logic       delivered;

    assign topic_end = item_valid && !item_stall && operation[0] && last;
    assign delivered = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(topic_end) - 4'(delivered);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(matched))
        else $error("stalled result changed");

    a_owed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 4'd0)
        else $error("result without an ended topic");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd6)
        else $error("more ended topics in flight than the design can hold");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid during reset");

endmodule

bind topic_filter_match tfm_checker u_tfm_checker (.*);

`default_nettype wire
